// ----- sv/gtg_pkg.sv -----
package gtg_pkg;

    // configuration port shape
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GOAL_X     = 3'd0,
        REG_GOAL_Y     = 3'd1,
        REG_GAIN_LIN   = 3'd2,
        REG_GAIN_ANG   = 3'd3,
        REG_ARRIVE_TOL = 3'd4
    } cfg_reg_t;

    // register reset values
    localparam logic [15:0] GAIN_LIN_RESET   = 16'd26;
    localparam logic [15:0] GAIN_ANG_RESET   = 16'd256;
    localparam logic [30:0] ARRIVE_TOL_RESET = 31'd6554;

    // cordic setup
    localparam int CORDIC_ITER_DEFAULT = 16;
    localparam logic signed [20:0] PI_Q16 = 21'sd205887;

    // arctangent of 2^-i in q16 radians
    function automatic logic [15:0] atan_q16(input logic [4:0] idx);
        logic [15:0] val;
        case (idx)
            5'd0:    val = 16'd51472;
            5'd1:    val = 16'd30386;
            5'd2:    val = 16'd16055;
            5'd3:    val = 16'd8150;
            5'd4:    val = 16'd4091;
            5'd5:    val = 16'd2047;
            5'd6:    val = 16'd1024;
            5'd7:    val = 16'd512;
            5'd8:    val = 16'd256;
            5'd9:    val = 16'd128;
            5'd10:   val = 16'd64;
            5'd11:   val = 16'd32;
            5'd12:   val = 16'd16;
            5'd13:   val = 16'd8;
            5'd14:   val = 16'd4;
            5'd15:   val = 16'd2;
            5'd16:   val = 16'd1;
            default: val = 16'd0;
        endcase
        return val;
    endfunction

endpackage

// ----- sv/gtg_req_if.sv -----
interface gtg_req_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] orient_z;

    modport source (output valid, output mode, output pos_x, output pos_y,
                    output orient_z, input ready);
    modport sink (input valid, input mode, input pos_x, input pos_y,
                  input orient_z, output ready);
endinterface

// ----- sv/gtg_cmd_if.sv -----
interface gtg_cmd_if;
    logic               valid;
    logic               ready;
    logic [30:0]        linear_cmd;
    logic signed [31:0] angular_cmd;
    logic               stop_flag;
    logic               last;

    modport source (output valid, output linear_cmd, output angular_cmd,
                    output stop_flag, output last, input ready);
    modport sink (input valid, input linear_cmd, input angular_cmd,
                  input stop_flag, input last, output ready);
endinterface

// ----- sv/go_to_goal_p_controller.sv -----
// channel  | dir | payload                                         | handshake
// req      | in  | mode, pos_x, pos_y, orient_z                    | valid/ready
// cmd      | out | linear_cmd, angular_cmd, stop_flag, last        | valid/ready
// cfg      | in  | cfg_index, cfg_data                             | cfg_we
//
// odometry transaction: capture, z squared, 33 sqrt steps, cordic init,
// rotations, heading; control tick: capture, 66 shift-add steps, 33 sqrt
// steps, cordic init, rotations, lin and ang terms, one or two command loads
// (these may stall); shared multiply, sqrt, cordic loops: one step per cycle
// req.ready is high only in idle; a command waiting in the output register
// does not block a new transaction, only the next command load
// async active-low reset clears pose, heading and configuration to defaults
module go_to_goal_p_controller
    import gtg_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    gtg_req_if.sink               req,
    gtg_cmd_if.source             cmd,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_ZSQ, S_MULX, S_MULY, S_SQRT, S_CINIT, S_CORD,
        S_HEAD, S_LIN, S_ANG, S_EMIT1, S_EMIT2
    } state_t;

    localparam logic [4:0] CORD_LAST = 5'(CORDIC_ITERATIONS - 1);
    localparam logic [5:0] STEP_LAST = 6'd32;

    // configuration registers
    logic signed [31:0] goal_x_reg, goal_y_reg;
    logic [15:0]        gain_lin_reg, gain_ang_reg;
    logic [30:0]        tol_reg;

    // control state and output registers
    state_t             state_reg, state_next;
    logic signed [31:0] pose_x_reg, pose_x_next, pose_y_reg, pose_y_next;
    logic signed [15:0] heading_reg, heading_next;
    logic               cmd_valid_reg, cmd_valid_next;
    logic [30:0]        cmd_lin_reg, cmd_lin_next;
    logic signed [31:0] cmd_ang_reg, cmd_ang_next;
    logic               cmd_stop_reg, cmd_stop_next, cmd_last_reg, cmd_last_next;

    // datapath registers
    logic               mode_reg, mode_next;
    logic signed [32:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [15:0] z_reg, z_next;
    logic [65:0]        mcand_reg, mcand_next, acc_reg, acc_next;
    logic [32:0]        mplier_reg, mplier_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [35:0]        rem_reg, rem_next;
    logic [32:0]        root_reg, root_next;
    logic signed [35:0] x_reg, x_next, y_reg, y_next;
    logic signed [20:0] ang_reg, ang_next;
    logic [4:0]         cidx_reg, cidx_next;
    logic [30:0]        lin_reg, lin_next;
    logic               arrived_reg, arrived_next;
    logic signed [17:0] err_reg, err_next;
    logic signed [31:0] angc_reg, angc_next;

    function automatic logic [32:0] abs33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    // combinational step helpers
    logic signed [31:0] zsq;
    logic signed [31:0] rad31;
    logic [35:0]        rem_sh, trial;
    logic signed [35:0] xi, yi, xs, ys;
    logic signed [20:0] atan_s;
    logic signed [23:0] h_sum, h_sh;
    logic [48:0]        lin_prod;
    logic signed [21:0] b_sum, b_sh, err_w;
    logic signed [34:0] ang_prod, ang_sh;

    assign req.ready       = (state_reg == S_IDLE);
    assign cmd.valid       = cmd_valid_reg;
    assign cmd.linear_cmd  = cmd_lin_reg;
    assign cmd.angular_cmd = cmd_ang_reg;
    assign cmd.stop_flag   = cmd_stop_reg;
    assign cmd.last        = cmd_last_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg   <= '0;
            goal_y_reg   <= '0;
            gain_lin_reg <= GAIN_LIN_RESET;
            gain_ang_reg <= GAIN_ANG_RESET;
            tol_reg      <= ARRIVE_TOL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GOAL_X:     goal_x_reg   <= cfg_data;
                REG_GOAL_Y:     goal_y_reg   <= cfg_data;
                REG_GAIN_LIN:   gain_lin_reg <= cfg_data[15:0];
                REG_GAIN_ANG:   gain_ang_reg <= cfg_data[15:0];
                REG_ARRIVE_TOL: tol_reg      <= cfg_data[30:0];
                default:        ;
            endcase
        end
    end

    // shared step arithmetic
    always_comb
    begin
        zsq    = z_reg * z_reg;
        rad31  = 32'sd1073741824 - zsq;
        rem_sh = {rem_reg[33:0], acc_reg[65:64]};
        trial  = {1'b0, root_reg, 2'b01};
        if (mode_reg)
        begin
            xi = 36'(dx_reg);
            yi = 36'(dy_reg);
        end
        else
        begin
            xi = {3'b000, root_reg};
            yi = 36'(z_reg);
        end
        xs       = x_reg >>> cidx_reg;
        ys       = y_reg >>> cidx_reg;
        atan_s   = $signed({5'b00000, atan_q16(cidx_reg)});
        h_sum    = $signed({ang_reg[20], ang_reg, 2'b00}) >>> 1;
        h_sum    = h_sum + 24'sd4;
        h_sh     = h_sum >>> 3;
        lin_prod = 49'(gain_lin_reg) * 49'(root_reg);
        b_sum    = 22'(ang_reg) + 22'sd4;
        b_sh     = b_sum >>> 3;
        err_w    = b_sh - 22'(heading_reg);
        ang_prod = $signed({1'b0, gain_ang_reg}) * err_reg;
        ang_sh   = ang_prod >>> 5;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        pose_x_next    = pose_x_reg;
        pose_y_next    = pose_y_reg;
        heading_next   = heading_reg;
        cmd_valid_next = cmd_valid_reg && !cmd.ready;
        cmd_lin_next   = cmd_lin_reg;
        cmd_ang_next   = cmd_ang_reg;
        cmd_stop_next  = cmd_stop_reg;
        cmd_last_next  = cmd_last_reg;
        mode_next      = mode_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        z_next         = z_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        ang_next       = ang_reg;
        cidx_next      = cidx_reg;
        lin_next       = lin_reg;
        arrived_next   = arrived_reg;
        err_next       = err_reg;
        angc_next      = angc_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next = req.mode;
                    if (req.mode)
                    begin
                        dx_next     = 33'(goal_x_reg) - 33'(pose_x_reg);
                        dy_next     = 33'(goal_y_reg) - 33'(pose_y_reg);
                        mcand_next  = 66'(abs33(dx_next));
                        mplier_next = abs33(dx_next);
                        acc_next    = '0;
                        cnt_next    = '0;
                        state_next  = S_MULX;
                    end
                    else
                    begin
                        pose_x_next = req.pos_x;
                        pose_y_next = req.pos_y;
                        z_next      = req.orient_z;
                        state_next  = S_ZSQ;
                    end
                end
            end
            S_ZSQ:
            begin
                acc_next   = {34'd0, rad31[31:0]};
                cnt_next   = '0;
                rem_next   = '0;
                root_next  = '0;
                state_next = S_SQRT;
            end
            // shift-add squaring, both squares summed into acc
            S_MULX, S_MULY:
            begin
                acc_next    = acc_reg + (mplier_reg[0] ? mcand_reg : 66'd0);
                mcand_next  = {mcand_reg[64:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[32:1]};
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg == STEP_LAST)
                begin
                    cnt_next = '0;
                    if (state_reg == S_MULX)
                    begin
                        mcand_next  = 66'(abs33(dy_reg));
                        mplier_next = abs33(dy_reg);
                        state_next  = S_MULY;
                    end
                    else
                    begin
                        rem_next   = '0;
                        root_next  = '0;
                        state_next = S_SQRT;
                    end
                end
            end
            // restoring square root, one bit pair a step
            S_SQRT:
            begin
                acc_next = {acc_reg[63:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[31:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[31:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == STEP_LAST)
                begin
                    state_next = S_CINIT;
                end
            end
            // quadrant fold, zero vector skips the rotations
            S_CINIT:
            begin
                cidx_next = '0;
                ang_next  = '0;
                x_next    = xi;
                y_next    = yi;
                if (xi == 36'sd0 && yi == 36'sd0)
                begin
                    state_next = mode_reg ? S_LIN : S_HEAD;
                end
                else
                begin
                    if (xi < 36'sd0)
                    begin
                        ang_next = (yi >= 36'sd0) ? PI_Q16 : -PI_Q16;
                        x_next   = -xi;
                        y_next   = -yi;
                    end
                    state_next = S_CORD;
                end
            end
            // cordic vectoring rotation
            S_CORD:
            begin
                if (y_reg > 36'sd0)
                begin
                    x_next   = x_reg + ys;
                    y_next   = y_reg - xs;
                    ang_next = ang_reg + atan_s;
                end
                else
                begin
                    x_next   = x_reg - ys;
                    y_next   = y_reg + xs;
                    ang_next = ang_reg - atan_s;
                end
                cidx_next = cidx_reg + 5'd1;
                if (cidx_reg == CORD_LAST)
                begin
                    state_next = mode_reg ? S_LIN : S_HEAD;
                end
            end
            // heading = 2*asin, rounded and clamped
            S_HEAD:
            begin
                if (h_sh > 24'sd32767)
                begin
                    heading_next = 16'sh7FFF;
                end
                else if (h_sh < -24'sd32768)
                begin
                    heading_next = -16'sh8000;
                end
                else
                begin
                    heading_next = h_sh[15:0];
                end
                state_next = S_IDLE;
            end
            S_LIN:
            begin
                lin_next     = (|lin_prod[48:39]) ? 31'h7FFFFFFF : lin_prod[38:8];
                arrived_next = root_reg < {2'b00, tol_reg};
                err_next     = err_w[17:0];
                state_next   = S_ANG;
            end
            // turn rate held aside until the output register is free
            S_ANG:
            begin
                if (ang_sh > 35'sd2147483647)
                begin
                    angc_next = 32'sh7FFFFFFF;
                end
                else if (ang_sh < -35'sd2147483648)
                begin
                    angc_next = 32'sh80000000;
                end
                else
                begin
                    angc_next = ang_sh[31:0];
                end
                state_next = S_EMIT1;
            end
            S_EMIT1:
            begin
                if (!cmd_valid_reg || cmd.ready)
                begin
                    cmd_valid_next = 1'b1;
                    cmd_lin_next   = lin_reg;
                    cmd_ang_next   = angc_reg;
                    cmd_stop_next  = 1'b0;
                    cmd_last_next  = !arrived_reg;
                    state_next     = arrived_reg ? S_EMIT2 : S_IDLE;
                end
            end
            S_EMIT2:
            begin
                if (!cmd_valid_reg || cmd.ready)
                begin
                    cmd_valid_next = 1'b1;
                    cmd_lin_next   = '0;
                    cmd_ang_next   = '0;
                    cmd_stop_next  = 1'b1;
                    cmd_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, pose and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pose_x_reg    <= '0;
            pose_y_reg    <= '0;
            heading_reg   <= '0;
            cmd_valid_reg <= 1'b0;
            cmd_lin_reg   <= '0;
            cmd_ang_reg   <= '0;
            cmd_stop_reg  <= 1'b0;
            cmd_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pose_x_reg    <= pose_x_next;
            pose_y_reg    <= pose_y_next;
            heading_reg   <= heading_next;
            cmd_valid_reg <= cmd_valid_next;
            cmd_lin_reg   <= cmd_lin_next;
            cmd_ang_reg   <= cmd_ang_next;
            cmd_stop_reg  <= cmd_stop_next;
            cmd_last_reg  <= cmd_last_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        z_reg       <= z_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        acc_reg     <= acc_next;
        cnt_reg     <= cnt_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        ang_reg     <= ang_next;
        cidx_reg    <= cidx_next;
        lin_reg     <= lin_next;
        arrived_reg <= arrived_next;
        err_reg     <= err_next;
        angc_reg    <= angc_next;
    end

    // stop command carries zero speeds and closes the tick
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.stop_flag |->
            cmd.linear_cmd == 31'd0 && cmd.angular_cmd == 32'sd0 && cmd.last)
        else $error("stop command not zero or not last");

    // a command that is not last is never the stop command
    a_first_not_stop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && !cmd.last |-> !cmd.stop_flag)
        else $error("stop flag on a non-final command");

    // busy right after a transaction is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("ready high right after accept");

    // a command load never drops a waiting one
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && !cmd.ready |=> cmd.valid && $stable(cmd.linear_cmd)
            && $stable(cmd.angular_cmd) && $stable(cmd.stop_flag))
        else $error("waiting command overwritten");

endmodule

// ----- bench/go_to_goal_p_controller_tb.sv -----
`timescale 1ns / 1ps

module go_to_goal_p_controller_tb;
    import gtg_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES  = 250;
    localparam int ITER           = CORDIC_ITER_DEFAULT;
    localparam int RAND_PER_PHASE = 215;

    typedef struct {
        logic [30:0]        linear;
        logic signed [31:0] angular;
        logic               stop;
        logic               last;
    } drive_cmd_t;

    typedef struct {
        logic               mode;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] oz;
        logic               literal;
    } stim_row_t;

    // arctangent of 2^-i, q16 radians
    localparam longint ATAN_STEP [0:16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
        512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    localparam longint HALF_TURN_Q16 = 205887;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gtg_req_if req_if ();
    gtg_cmd_if cmd_if ();

    go_to_goal_p_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if.sink),
        .cmd       (cmd_if.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // controller state mirror
    logic signed [31:0] goal_x, goal_y, pose_x, pose_y;
    logic [15:0]        gain_lin, gain_ang;
    logic [30:0]        tol;
    logic signed [15:0] heading;

    drive_cmd_t pending_cmds [$];
    int fail_count = 0;
    int idle_cycles = 0;
    int n_odom = 0, n_tick = 0, n_cmds = 0, n_stops = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 200);
    endfunction

    // floor square root of a 66 bit value
    function automatic logic [32:0] floor_root(logic [65:0] v);
        logic [67:0] root, rem, trial;
        root = '0;
        rem  = '0;
        for (int i = 32; i >= 0; i--) begin
            rem   = (rem << 2) | 68'(v[2*i +: 2]);
            trial = (root << 2) | 68'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 68'd1;
            end
            else begin
                root = root << 1;
            end
        end
        return root[32:0];
    endfunction

    // vectoring-mode angle of (x, y), q16 radians
    function automatic longint vector_angle(longint y, longint x);
        longint ang, xs, ys;
        ang = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            ang = (y >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ITER; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x   = x + ys;
                y   = y - xs;
                ang = ang + ((i <= 16) ? ATAN_STEP[i] : 0);
            end
            else begin
                x   = x - ys;
                y   = y + xs;
                ang = ang - ((i <= 16) ? ATAN_STEP[i] : 0);
            end
        end
        return ang;
    endfunction

    // update pose and heading from an odometry sample
    task automatic update_pose(logic signed [31:0] px, logic signed [31:0] py,
                               logic signed [15:0] oz);
        longint z, c, h;
        z = oz;
        c = longint'(floor_root(66'((64'sd1 <<< 30) - z * z)));
        h = (2 * vector_angle(z, c) + 4) >>> 3;
        if (h > 32767) h = 32767;
        if (h < -32768) h = -32768;
        pose_x  = px;
        pose_y  = py;
        heading = h[15:0];
    endtask

    // drive commands caused by a control tick
    task automatic predict_drive();
        longint dx, dy, ax, ay, bearing, err, ang;
        logic [65:0] sum_sq, lin;
        logic [32:0] dist_q16;
        drive_cmd_t c;
        dx = longint'(goal_x) - longint'(pose_x);
        dy = longint'(goal_y) - longint'(pose_y);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        sum_sq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
        dist_q16 = floor_root(sum_sq);
        lin = (66'(gain_lin) * 66'(dist_q16)) >> 8;
        if (lin > 66'h7FFF_FFFF) lin = 66'h7FFF_FFFF;
        bearing = (vector_angle(dy, dx) + 4) >>> 3;
        err = bearing - longint'(heading);
        ang = (longint'(gain_ang) * err) >>> 5;
        if (ang > 64'sd2147483647) ang = 64'sd2147483647;
        if (ang < -64'sd2147483648) ang = -64'sd2147483648;
        c.linear  = lin[30:0];
        c.angular = ang[31:0];
        c.stop    = 1'b0;
        c.last    = (dist_q16 < 33'(tol)) ? 1'b0 : 1'b1;
        pending_cmds.push_back(c);
        if (!c.last) begin
            c.linear  = '0;
            c.angular = '0;
            c.stop    = 1'b1;
            c.last    = 1'b1;
            pending_cmds.push_back(c);
        end
    endtask

    // send one transaction on the request channel
    task automatic send_req(logic mode, logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [15:0] oz);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.mode     <= mode;
        req_if.pos_x    <= px;
        req_if.pos_y    <= py;
        req_if.orient_z <= oz;
        do @(posedge clk); while (!req_if.ready);
        if (mode) n_tick++;
        else n_odom++;
    endtask

    task automatic write_reg(cfg_reg_t r, logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        case (r)
            REG_GOAL_X:     goal_x = v;
            REG_GOAL_Y:     goal_y = v;
            REG_GAIN_LIN:   gain_lin = v[15:0];
            REG_GAIN_ANG:   gain_ang = v[15:0];
            REG_ARRIVE_TOL: tol = v[30:0];
            default: ;
        endcase
    endtask

    // wait until every command is back and the block is quiet
    task automatic drain();
        req_if.valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sink side: random stalls and result checking
    int stall_left = 0;
    always @(posedge clk) begin
        if (rst_n && cmd_if.valid && cmd_if.ready) begin
            n_cmds++;
            if (cmd_if.stop_flag) n_stops++;
            if (pending_cmds.size() == 0) begin
                $error("unexpected command: linear %0d angular %0d",
                       cmd_if.linear_cmd, cmd_if.angular_cmd);
                fail_count++;
            end
            else begin
                drive_cmd_t e;
                e = pending_cmds.pop_front();
                if (cmd_if.linear_cmd !== e.linear) begin
                    $error("linear_cmd expected %0d actual %0d", e.linear, cmd_if.linear_cmd);
                    fail_count++;
                end
                if (cmd_if.angular_cmd !== e.angular) begin
                    $error("angular_cmd expected %0d actual %0d", e.angular,
                           cmd_if.angular_cmd);
                    fail_count++;
                end
                if (cmd_if.stop_flag !== e.stop) begin
                    $error("stop_flag expected %0b actual %0b", e.stop, cmd_if.stop_flag);
                    fail_count++;
                end
                if (cmd_if.last !== e.last) begin
                    $error("last expected %0b actual %0b", e.last, cmd_if.last);
                    fail_count++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            cmd_if.ready <= 1'b0;
        end
        else begin
            stall_left = pick_gap();
            cmd_if.ready <= (stall_left == 0);
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (cmd_if.valid && cmd_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d commands outstanding", pending_cmds.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // directed rows, tick right after reset has a known answer
    stim_row_t directed [] = '{
        '{1'b1, 32'sd0, 32'sd0, 16'sd0, 1'b1},
        '{1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh7FFF, 1'b0},
        '{1'b1, 32'sd0, 32'sd0, 16'sd0, 1'b0},
        '{1'b0, 32'sh8000_0000, 32'sh8000_0000, 16'sh8000, 1'b0},
        '{1'b1, 32'sd0, 32'sd0, 16'sd0, 1'b0},
        '{1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'sd0, 1'b0},
        '{1'b1, 32'sh1234_5678, -32'sd9, 16'sh7FFF, 1'b0},
        '{1'b0, -32'sd1, 32'sd1, 16'sd12345, 1'b0},
        '{1'b1, 32'sd0, 32'sd0, 16'sd0, 1'b0},
        '{1'b0, 32'sd100, -32'sd100, -16'sd20000, 1'b0},
        '{1'b1, 32'sd0, 32'sd0, 16'sd0, 1'b0},
        '{1'b0, -32'sd6554, 32'sd0, 16'sd1, 1'b0},
        '{1'b1, 32'sd0, 32'sd0, 16'sd0, 1'b0},
        '{1'b0, 32'sd0, 32'sd6553, -16'sd1, 1'b0},
        '{1'b1, 32'sd0, 32'sd0, 16'sd0, 1'b0},
        '{1'b0, 32'sh0001_0000, 32'sh0001_0000, 16'sd23170, 1'b0},
        '{1'b1, 32'sd0, 32'sd0, 16'sd0, 1'b0}
    };

    // settings per phase: goal x, goal y, gains, tolerance
    logic [31:0] phase_goal_x [5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0003_0000, 0, 0};
    logic [31:0] phase_goal_y [5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFE_8000, 0, 0};
    logic [15:0] phase_gain_l [5] = '{16'hFFFF, 16'd0, 16'd26, 16'd1, 16'd300};
    logic [15:0] phase_gain_a [5] = '{16'hFFFF, 16'd0, 16'd256, 16'hFFFF, 16'd1};
    logic [30:0] phase_tol    [5] = '{31'h7FFF_FFFF, 31'd0, 31'd6554, 31'd65536, 31'd1};

    initial begin
        drive_cmd_t lit;
        logic signed [31:0] px, py;
        logic signed [15:0] oz;
        logic m;
        int r;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        req_if.valid = 1'b0;
        req_if.mode  = 1'b0;
        req_if.pos_x = '0;
        req_if.pos_y = '0;
        req_if.orient_z = '0;
        cmd_if.ready = 1'b0;
        goal_x   = 0;
        goal_y   = 0;
        gain_lin = GAIN_LIN_RESET;
        gain_ang = GAIN_ANG_RESET;
        tol      = ARRIVE_TOL_RESET;
        pose_x   = 0;
        pose_y   = 0;
        heading  = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed table under reset settings
        foreach (directed[i]) begin
            send_req(directed[i].mode, directed[i].px, directed[i].py, directed[i].oz);
            if (directed[i].literal) begin
                lit = '{31'd0, 32'sd0, 1'b0, 1'b0};
                pending_cmds.push_back(lit);
                lit = '{31'd0, 32'sd0, 1'b1, 1'b1};
                pending_cmds.push_back(lit);
            end
            else if (directed[i].mode) predict_drive();
            else update_pose(directed[i].px, directed[i].py, directed[i].oz);
        end

        // random phases, each with its own register settings
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            if (ph < 5) begin
                write_reg(REG_GOAL_X, phase_goal_x[ph]);
                write_reg(REG_GOAL_Y, phase_goal_y[ph]);
                write_reg(REG_GAIN_LIN, 32'(phase_gain_l[ph]));
                write_reg(REG_GAIN_ANG, 32'(phase_gain_a[ph]));
                write_reg(REG_ARRIVE_TOL, 32'(phase_tol[ph]));
            end
            else begin
                write_reg(REG_GOAL_X, $urandom());
                write_reg(REG_GOAL_Y, $urandom());
                write_reg(REG_GAIN_LIN, $urandom_range(0, 65535));
                write_reg(REG_GAIN_ANG, $urandom_range(0, 65535));
                write_reg(REG_ARRIVE_TOL, $urandom_range(0, 200000));
            end
            cfg_we <= 1'b0;
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                m = $urandom_range(0, 1);
                r = $urandom_range(0, 9);
                if (r < 4) begin
                    // near the goal, often inside the tolerance
                    px = goal_x + 32'($signed($urandom_range(0, 16000)) - 8000);
                    py = goal_y + 32'($signed($urandom_range(0, 16000)) - 8000);
                end
                else if (r < 5) begin
                    px = ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                    py = ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                end
                else begin
                    px = $urandom();
                    py = $urandom();
                end
                r = $urandom_range(0, 9);
                if (r == 0) oz = 16'sh7FFF;
                else if (r == 1) oz = 16'sh8000;
                else oz = $urandom();
                send_req(m, px, py, oz);
                if (m) predict_drive();
                else update_pose(px, py, oz);
            end
        end

        drain();
        $display("covered %0d odometry samples and %0d control ticks over 7 settings",
                 n_odom, n_tick);
        $display("checked %0d drive commands, %0d of them arrival stops", n_cmds, n_stops);
        if (fail_count == 0 && pending_cmds.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
